/* src/fpm_pkg.sv */
// Package for the fuzzy path match scorer: widths, scoring constants,
// register indexes, shared structs and byte helper functions.
// No dependencies; compiled first.
package fpm_pkg;

    localparam int MAX_QUERY_LEN = 32;
    localparam int MAX_PATH_LEN  = 4096;

    localparam int BYTE_W      = 8;
    localparam int QLEN_W      = 6;
    localparam int QPOS_W      = $clog2(MAX_QUERY_LEN + 1);
    localparam int QIDX_W      = $clog2(MAX_QUERY_LEN);
    localparam int PATH_LEN_W  = $clog2(MAX_PATH_LEN + 1);
    localparam int RUN_SCORE_W = 11;
    localparam int SCORE_W     = 12;
    localparam int ADD_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int QWORDS      = (MAX_QUERY_LEN * BYTE_W) / CFG_DATA_W;

    // Score points
    localparam int PTS_MATCH    = 10;
    localparam int PTS_CONSEC   = 12;
    localparam int PTS_BOUNDARY = 18;
    localparam int PTS_EXACT    = 2;
    localparam int LEN_DIV_SHIFT = 2;   // length penalty is length / 4

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_WORD_3 = 3'd4;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_UPPER_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_CASE_OFS  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_DASH      = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT       = 8'h2E;

    typedef struct packed {
        logic [QPOS_W-1:0]                   qlen;   // clamped to MAX_QUERY_LEN
        logic [MAX_QUERY_LEN-1:0][BYTE_W-1:0] chars;
    } query_cfg_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      matched;
    } result_t;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            r = c + CH_CASE_OFS;
        return r;
    endfunction

    function automatic logic is_separator(input logic [BYTE_W-1:0] c);
        return (c == CH_SLASH) || (c == CH_BACKSLASH) || (c == CH_UNDERSCORE)
            || (c == CH_DASH) || (c == CH_DOT);
    endfunction

endpackage

/* src/fpm_if.sv */
// Channel interfaces of the fuzzy path match scorer: path input,
// result output and configuration write. Depends on fpm_pkg.
interface fpm_in_if;
    import fpm_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] cand_byte;
    logic              has_byte;
    logic              last;

    modport source (output valid, cand_byte, has_byte, last, input ready);
    modport sink   (input valid, cand_byte, has_byte, last, output ready);
endinterface

interface fpm_out_if;
    import fpm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;
    logic                      matched;

    modport source (output valid, score, matched, input ready);
    modport sink   (input valid, score, matched, output ready);
endinterface

interface fpm_cfg_if;
    import fpm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/fuzzy_path_match_scorer.sv */
// Top level of the fuzzy path match scorer: input register, scoring core,
// result register and configuration registers.
// Depends on fpm_pkg, fpm_if, fpm_cfg_regs and fpm_score_core.

// The block takes one path byte per transaction and sustains one transaction
// per clock. A transaction lands in the input register, and from there the
// scoring core updates the per-path state (query position, running score,
// length, previous byte) in one step: a 32-way query character select, a
// case-folded and an exact byte compare and a small add. A transaction with
// last set passes through the input register and then loads its result into
// the result register; the result waits there until taken, and bytes of the
// next path keep flowing meanwhile. Only a second last transaction stalls
// while the previous result is still unclaimed. has_byte low carries no path
// byte and is used to close a path (an empty path if nothing came before).
// Query registers are written through the cfg channel, which is always
// ready; write them only while no path is in flight.
module fuzzy_path_match_scorer (
    input  logic     clk,
    input  logic     rst_n,
    fpm_cfg_if.sink  cfg,
    fpm_in_if.sink   path,
    fpm_out_if.source result
);
    import fpm_pkg::*;

    query_cfg_t query;
    result_t    core_result;

    // Input register
    logic              in_vld_reg,  in_vld_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_has_reg;
    logic              in_last_reg;

    // Result register
    logic                      out_vld_reg, out_vld_next;
    logic signed [SCORE_W-1:0] out_score_reg;
    logic                      out_matched_reg;

    logic in_accept;
    logic out_free;
    logic step;

    fpm_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .query (query)
    );

    // Result slot is free when empty or being drained this cycle.
    assign out_free  = !out_vld_reg || result.ready;
    // Only an end-of-path item needs room in the result register.
    assign step      = in_vld_reg && (!in_last_reg || out_free);
    assign path.ready = !in_vld_reg || step;
    assign in_accept = path.valid && path.ready;

    fpm_score_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cand_byte (in_byte_reg),
        .has_byte  (in_has_reg),
        .last      (in_last_reg),
        .query     (query),
        .result    (core_result)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_accept)
            in_vld_next = 1'b1;
        else if (step)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (step && in_last_reg)
            out_vld_next = 1'b1;
        else if (result.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= path.cand_byte;
            in_has_reg  <= path.has_byte;
            in_last_reg <= path.last;
        end
        if (step && in_last_reg)
        begin
            out_score_reg   <= core_result.score;
            out_matched_reg <= core_result.matched;
        end
    end

    assign result.valid   = out_vld_reg;
    assign result.score   = out_score_reg;
    assign result.matched = out_matched_reg;

endmodule

/* src/fpm_cfg_regs.sv */
// Configuration register file: query length and the four query words.
// Depends on fpm_pkg and fpm_cfg_if.
module fpm_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    fpm_cfg_if.sink             cfg,
    output fpm_pkg::query_cfg_t query
);
    import fpm_pkg::*;

    logic [QLEN_W-1:0]                     qlen_reg;
    logic [QWORDS-1:0][CFG_DATA_W-1:0]     words_reg;
    logic                                  wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg  <= '0;
            words_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg.index)
                REG_QUERY_LENGTH: qlen_reg     <= cfg.data[QLEN_W-1:0];
                REG_QUERY_WORD_0: words_reg[0] <= cfg.data;
                REG_QUERY_WORD_1: words_reg[1] <= cfg.data;
                REG_QUERY_WORD_2: words_reg[2] <= cfg.data;
                REG_QUERY_WORD_3: words_reg[3] <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Lengths above the query capacity count as a full query.
    assign query.qlen  = (qlen_reg > QLEN_W'(MAX_QUERY_LEN)) ? QPOS_W'(MAX_QUERY_LEN)
                                                             : QPOS_W'(qlen_reg);
    assign query.chars = words_reg;

endmodule

/* src/fpm_score_core.sv */
// Per-path match state and the combinational scoring step.
// Depends on fpm_pkg.
module fpm_score_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          cand_byte,
    input  logic                has_byte,
    input  logic                last,
    input  fpm_pkg::query_cfg_t query,
    output fpm_pkg::result_t    result
);
    import fpm_pkg::*;

    logic [QPOS_W-1:0]      qpos_reg,      qpos_next;
    logic                   prev_hit_reg,  prev_hit_next;
    logic [BYTE_W-1:0]      prev_byte_reg, prev_byte_next;
    logic                   at_start_reg,  at_start_next;
    logic [RUN_SCORE_W-1:0] run_reg,       run_next;
    logic [PATH_LEN_W-1:0]  path_len_reg,  path_len_next;

    logic                   active;
    logic [BYTE_W-1:0]      qchar;
    logic                   hit;
    logic [ADD_W-1:0]       add_pts;
    logic [RUN_SCORE_W:0]   sum;
    logic [QPOS_W-1:0]      qpos_new;
    logic [RUN_SCORE_W-1:0] run_new;
    logic [PATH_LEN_W-1:0]  path_new;
    logic [SCORE_W-1:0]     diff;

    assign active = qpos_reg < query.qlen;
    assign qchar  = query.chars[qpos_reg[QIDX_W-1:0]];
    assign hit    = has_byte && active && (fold_case(cand_byte) == fold_case(qchar));

    assign add_pts = ADD_W'(PTS_MATCH)
                   + (prev_hit_reg ? ADD_W'(PTS_CONSEC) : ADD_W'(0))
                   + ((at_start_reg || is_separator(prev_byte_reg))
                        ? ADD_W'(PTS_BOUNDARY) : ADD_W'(0))
                   + ((cand_byte == qchar) ? ADD_W'(PTS_EXACT) : ADD_W'(0));

    assign sum      = {1'b0, run_reg} + (RUN_SCORE_W+1)'(add_pts);
    assign run_new  = hit ? (sum[RUN_SCORE_W] ? '1 : sum[RUN_SCORE_W-1:0]) : run_reg;
    assign qpos_new = hit ? qpos_reg + QPOS_W'(1) : qpos_reg;
    assign path_new = (has_byte && (path_len_reg < PATH_LEN_W'(MAX_PATH_LEN)))
                    ? path_len_reg + PATH_LEN_W'(1) : path_len_reg;

    // Running score is at most 2047 and the penalty at most 1024, so the
    // difference never drops below -1024.
    assign diff = SCORE_W'(run_new) - SCORE_W'(path_new >> LEN_DIV_SHIFT);

    always_comb
    begin
        priority if (query.qlen == '0)
        begin
            result.score   = '0;
            result.matched = 1'b1;
        end
        else if (qpos_new >= query.qlen)
        begin
            result.score   = $signed(diff);
            result.matched = 1'b1;
        end
        else
        begin
            result.score   = '1;
            result.matched = 1'b0;
        end
    end

    always_comb
    begin
        qpos_next      = qpos_new;
        run_next       = run_new;
        path_len_next  = path_new;
        prev_hit_next  = (has_byte && active) ? hit : prev_hit_reg;
        prev_byte_next = has_byte ? cand_byte : prev_byte_reg;
        at_start_next  = has_byte ? 1'b0 : at_start_reg;
        if (last)
        begin
            qpos_next      = '0;
            run_next       = '0;
            path_len_next  = '0;
            prev_hit_next  = 1'b0;
            prev_byte_next = '0;
            at_start_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qpos_reg      <= '0;
            prev_hit_reg  <= 1'b0;
            prev_byte_reg <= '0;
            at_start_reg  <= 1'b1;
            run_reg       <= '0;
            path_len_reg  <= '0;
        end
        else if (step)
        begin
            qpos_reg      <= qpos_next;
            prev_hit_reg  <= prev_hit_next;
            prev_byte_reg <= prev_byte_next;
            at_start_reg  <= at_start_next;
            run_reg       <= run_next;
            path_len_reg  <= path_len_next;
        end
    end

endmodule

/* src/fpm_checker.sv */
// Port-level checker for the fuzzy path match scorer, bound to the top level.
// Depends on fpm_pkg and fuzzy_path_match_scorer.
module fpm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              path_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic signed [fpm_pkg::SCORE_W-1:0] result_score,
    input logic                              result_matched
);
    import fpm_pkg::*;

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_score) && $stable(result_matched))
        else $error("result changed while stalled");

    // An unmatched query always reports -1.
    a_unmatched_score: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_matched |-> result_score == -SCORE_W'(1))
        else $error("unmatched result with score other than -1");

    // Matched scores never fall below the length-penalty floor.
    a_score_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_matched |-> result_score >= -12'sd1024)
        else $error("matched score below -1024");

    // Input back-pressure only occurs behind a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !path_ready |-> result_valid && !result_ready)
        else $error("input stalled without a pending result");

endmodule

bind fuzzy_path_match_scorer fpm_checker u_fpm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .path_ready     (path.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_score   (result.score),
    .result_matched (result.matched)
);
